FILE: rtl/lags_pkg.sv
// ----------------------------------------------------------------------------
// lags_pkg
// Shared constants, action and register codes, and controller/datapath
// command and status types for the life automaton generation step block.
// ----------------------------------------------------------------------------
package lags_pkg;

    localparam int MAX_ROWS_DEF = 128;
    localparam int MAX_COLS_DEF = 128;

    localparam int ACTION_W  = 2;
    localparam int IDX_W     = 7;
    localparam int CFG_W     = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 15;

    localparam logic [ACTION_W-1:0] ACT_WRITE   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_READ    = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_ADVANCE = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COL_COUNT = 2'd1;

    localparam logic [CFG_W-1:0] ROW_COUNT_RST = 8'd20;
    localparam logic [CFG_W-1:0] COL_COUNT_RST = 8'd40;

    // drain wait from the last row issue until the live count has settled
    localparam int DRAIN_LEN = 6;

    typedef struct packed {
        logic load_item;
        logic clear_acc;
        logic rd_en;
        logic src_top;
        logic capture_top;
        logic adv_mode;
        logic compute_en;
        logic load_out;
    } lags_cmd_t;

    typedef struct packed {
        logic is_advance;
    } lags_sts_t;

endpackage

FILE: rtl/lags_if.sv
// ----------------------------------------------------------------------------
// lags_if
// Valid/ready channels of the block: item input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface lags_in_if;
    import lags_pkg::*;

    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [IDX_W-1:0]    row_index;
    logic [IDX_W-1:0]    col_index;
    logic                new_value;

    modport source (output valid, action, row_index, col_index, new_value, input ready);
    modport sink   (input valid, action, row_index, col_index, new_value, output ready);
endinterface

interface lags_out_if;
    import lags_pkg::*;

    logic             valid;
    logic             ready;
    logic             read_value;
    logic [CNT_W-1:0] live_count;
    logic             out_of_range;

    modport source (output valid, read_value, live_count, out_of_range, input ready);
    modport sink   (input valid, read_value, live_count, out_of_range, output ready);
endinterface

interface lags_cfg_if;
    import lags_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/lags_ram.sv
// ----------------------------------------------------------------------------
// lags_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module lags_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 128,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/lags_ctrl.sv
// ----------------------------------------------------------------------------
// lags_ctrl
// Sequencer: takes an item, sweeps the rows in use through the datapath
// (advance or modify pass), waits for the live count to settle and hands
// the result to the output register.
// ----------------------------------------------------------------------------
module lags_ctrl #(
    parameter int MAX_ROWS = lags_pkg::MAX_ROWS_DEF,
    localparam int ROW_W   = $clog2(MAX_ROWS),
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1)
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output lags_pkg::lags_cmd_t cmd,
    output logic [ROW_W-1:0]    rd_addr,
    output logic [ROW_W-1:0]    cmp_row,
    input  lags_pkg::lags_sts_t sts,
    input  logic [RCNT_W-1:0]   rows
);
    import lags_pkg::*;

    localparam int KW = $clog2(MAX_ROWS + 2);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_PREP  = 3'd1;
    localparam logic [2:0] S_ADV   = 3'd2;
    localparam logic [2:0] S_SWEEP = 3'd3;
    localparam logic [2:0] S_DRAIN = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    logic [2:0]    state_reg, state_next;
    logic [KW-1:0] k_reg, k_next;
    logic          out_valid_reg, out_valid_next;
    logic [KW-1:0] rows_k;
    logic [KW-1:0] k_m1;
    logic [KW-1:0] k_m2;
    logic [RCNT_W-1:0] rows_m1;

    assign rows_k  = KW'(rows);
    assign k_m1    = k_reg - 1'b1;
    assign k_m2    = k_reg - 2'd2;
    assign rows_m1 = rows - 1'b1;

    always_comb
    begin
        state_next     = state_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        rd_addr        = '0;
        cmp_row        = k_m2[ROW_W-1:0];
        item_ready     = 1'b0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.clear_acc = 1'b1;
                k_next        = '0;
                state_next    = sts.is_advance ? S_ADV : S_SWEEP;
            end
            S_ADV:
            begin
                // stream: last row, rows 0..last, then the saved top row
                cmd.adv_mode    = 1'b1;
                cmd.capture_top = (k_reg == KW'(1));
                cmd.compute_en  = (k_reg >= KW'(2));
                if (k_reg == rows_k + 1'b1)
                begin
                    cmd.src_top = 1'b1;
                    k_next      = '0;
                    state_next  = S_DRAIN;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    rd_addr   = (k_reg == '0) ? rows_m1[ROW_W-1:0] : k_m1[ROW_W-1:0];
                    k_next    = k_reg + 1'b1;
                end
            end
            S_SWEEP:
            begin
                cmd.rd_en = 1'b1;
                rd_addr   = k_reg[ROW_W-1:0];
                k_next    = k_reg + 1'b1;
                if (k_reg == rows_k - 1'b1)
                begin
                    k_next     = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                k_next = k_reg + 1'b1;
                if (k_reg == KW'(DRAIN_LEN - 1))
                begin
                    k_next     = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.load_out   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef NO_ASSERTIONS
    a_load_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!out_valid_reg || out_ready))
        else $error("result loaded over an untaken result");

    a_no_read_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN || state_reg == S_DONE) |-> !cmd.rd_en)
        else $error("row read issued after the sweep ended");

    a_adv_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ADV) |-> (k_reg <= rows_k + 1'b1))
        else $error("advance counter ran past the window");

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && item_ready) |=> (state_reg == S_PREP))
        else $error("accepted item did not start a pass");
`endif

endmodule

FILE: rtl/lags_dp.sv
// ----------------------------------------------------------------------------
// lags_dp
// Row-wide datapath: size registers, grid RAM with row valid bits, three-row
// neighbourhood window with B3/S23 lanes, cell write/read path and the
// pipelined live-cell counter.
// ----------------------------------------------------------------------------
module lags_dp #(
    parameter int MAX_ROWS = lags_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lags_pkg::MAX_COLS_DEF,
    localparam int ROW_W   = $clog2(MAX_ROWS),
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lags_pkg::lags_cmd_t             cmd,
    input  logic [ROW_W-1:0]                rd_addr,
    input  logic [ROW_W-1:0]                cmp_row,
    output lags_pkg::lags_sts_t             sts,
    output logic [RCNT_W-1:0]               rows,
    input  logic [lags_pkg::ACTION_W-1:0]   action,
    input  logic [lags_pkg::IDX_W-1:0]      row_index,
    input  logic [lags_pkg::IDX_W-1:0]      col_index,
    input  logic                            new_value,
    input  logic                            cfg_we,
    input  logic [lags_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [lags_pkg::CFG_W-1:0]      cfg_data,
    output logic                            read_value,
    output logic [lags_pkg::CNT_W-1:0]      live_count,
    output logic                            out_of_range
);
    import lags_pkg::*;

    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int NBYTE  = (MAX_COLS + 7) / 8;
    localparam int NGRP   = (NBYTE + 7) / 8;
    localparam int NB     = NGRP * 8;

    // size registers
    logic [CFG_W-1:0]  row_count_reg;
    logic [CFG_W-1:0]  col_count_reg;
    logic [RCNT_W-1:0] nr;
    logic [CCNT_W-1:0] nc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg <= ROW_COUNT_RST;
            col_count_reg <= COL_COUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ROW_COUNT: row_count_reg <= cfg_data;
                REG_COL_COUNT: col_count_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        if (row_count_reg == '0)
            nr = RCNT_W'(1);
        else if (int'(row_count_reg) > MAX_ROWS)
            nr = RCNT_W'(MAX_ROWS);
        else
            nr = RCNT_W'(row_count_reg);

        if (col_count_reg == '0)
            nc = CCNT_W'(1);
        else if (int'(col_count_reg) > MAX_COLS)
            nc = CCNT_W'(MAX_COLS);
        else
            nc = CCNT_W'(col_count_reg);
    end

    assign rows = nr;

    // item registers
    logic [ACTION_W-1:0] action_reg;
    logic [IDX_W-1:0]    ri_reg;
    logic [IDX_W-1:0]    ci_reg;
    logic                val_reg;
    logic                inside_reg;
    logic                in_window;

    assign in_window = (int'(row_index) < int'(nr)) && (int'(col_index) < int'(nc));

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            action_reg <= action;
            ri_reg     <= row_index;
            ci_reg     <= col_index;
            val_reg    <= new_value;
            inside_reg <= in_window;
        end
    end

    assign sts.is_advance = (action_reg == ACT_ADVANCE);

    // grid memory with per-row valid bits, a row never written reads as dead
    logic                ram_we;
    logic [ROW_W-1:0]    ram_waddr;
    logic [MAX_COLS-1:0] ram_wdata;
    logic [MAX_COLS-1:0] ram_rdata;
    logic [MAX_ROWS-1:0] row_valid_reg;

    lags_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (ram_we)
        begin
            row_valid_reg[ram_waddr] <= 1'b1;
        end
    end

    // arrival stage
    lags_cmd_t  p1_cmd_reg;
    logic [ROW_W-1:0] p1_addr_reg;
    logic [ROW_W-1:0] p1_crow_reg;
    logic             p1_vld_reg;
    logic             p2_cen_reg;
    logic [ROW_W-1:0] p2_row_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_cmd_reg <= '0;
            p2_cen_reg <= 1'b0;
        end
        else
        begin
            p1_cmd_reg <= cmd;
            p2_cen_reg <= p1_cmd_reg.compute_en;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_addr_reg <= rd_addr;
        p1_crow_reg <= cmp_row;
        p1_vld_reg  <= row_valid_reg[rd_addr];
        p2_row_reg  <= p1_crow_reg;
    end

    logic [MAX_COLS-1:0] rrow;
    assign rrow = ram_rdata & {MAX_COLS{p1_vld_reg}};

    // three-row window of old rows
    logic [MAX_COLS-1:0] win_reg [3];
    logic [MAX_COLS-1:0] top_reg;

    always_ff @(posedge clk)
    begin
        if (p1_cmd_reg.adv_mode && (p1_cmd_reg.rd_en || p1_cmd_reg.src_top))
        begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= p1_cmd_reg.src_top ? top_reg : rrow;
        end
        if (p1_cmd_reg.capture_top)
        begin
            top_reg <= rrow;
        end
    end

    // column masks
    logic [MAX_COLS-1:0] colmask;
    logic [MAX_COLS-1:0] lastsel;
    logic [MAX_COLS-1:0] ci_hot;

    // wrapped left and right neighbour rows
    logic [MAX_COLS-1:0] win_l [3];
    logic [MAX_COLS-1:0] win_r [3];
    logic [2:0]          lastbit;
    logic [MAX_COLS-1:0] nxt_row;

    genvar c, w;
    generate
        for (c = 0; c < MAX_COLS; c++)
        begin : g_col
            logic [3:0] nsum;

            assign colmask[c] = (c < int'(nc));
            assign lastsel[c] = (int'(nc) == c + 1);
            assign ci_hot[c]  = (int'(ci_reg) == c);

            for (w = 0; w < 3; w++)
            begin : g_win
                if (c == 0)
                begin : g_first
                    assign win_l[w][c] = lastbit[w];
                end
                else
                begin : g_mid_l
                    assign win_l[w][c] = win_reg[w][c-1];
                end
                if (c == MAX_COLS - 1)
                begin : g_last
                    assign win_r[w][c] = lastsel[c] & win_reg[w][0];
                end
                else
                begin : g_mid_r
                    assign win_r[w][c] = lastsel[c] ? win_reg[w][0] : win_reg[w][c+1];
                end
            end

            assign nsum = 4'(win_l[0][c]) + 4'(win_reg[0][c]) + 4'(win_r[0][c])
                        + 4'(win_l[1][c]) + 4'(win_r[1][c])
                        + 4'(win_l[2][c]) + 4'(win_reg[2][c]) + 4'(win_r[2][c]);

            // born on three, survive on two or three, columns outside kept
            assign nxt_row[c] = colmask[c]
                              ? ((nsum == 4'd3) || (win_reg[1][c] && nsum == 4'd2))
                              : win_reg[1][c];
        end

        for (w = 0; w < 3; w++)
        begin : g_lastbit
            assign lastbit[w] = |(win_reg[w] & lastsel);
        end
    endgenerate

    // modify pass: cell write and read on the arriving row
    logic                m_en;
    logic                hit;
    logic                wr_hit;
    logic                rd_hit;
    logic [MAX_COLS-1:0] mod_row;
    logic                rd_bit_reg;

    assign m_en    = p1_cmd_reg.rd_en && !p1_cmd_reg.adv_mode;
    assign hit     = m_en && inside_reg && (int'(ri_reg) == int'(p1_addr_reg));
    assign wr_hit  = hit && (action_reg == ACT_WRITE);
    assign rd_hit  = hit && (action_reg == ACT_READ);
    assign mod_row = wr_hit ? ((rrow & ~ci_hot) | (ci_hot & {MAX_COLS{val_reg}})) : rrow;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rd_bit_reg <= 1'b0;
        end
        else if (rd_hit)
        begin
            rd_bit_reg <= |(rrow & ci_hot);
        end
    end

    assign ram_we    = wr_hit || p2_cen_reg;
    assign ram_waddr = p2_cen_reg ? p2_row_reg : p1_addr_reg;
    assign ram_wdata = p2_cen_reg ? nxt_row : mod_row;

    // live count: masked row, byte counts, group sums, accumulate
    logic [MAX_COLS-1:0] c1_row_reg;
    logic                c1_vld_reg;
    logic [3:0]          c2_reg [NB];
    logic                c2_vld_reg;
    logic [6:0]          c3_reg [NGRP];
    logic                c3_vld_reg;
    logic [CNT_W-1:0]    acc_reg;
    logic [NB*8-1:0]     pad_row;
    logic [3:0]          byte_cnt [NB];
    logic [6:0]          grp_sum [NGRP];
    logic [CNT_W-1:0]    row_sum;

    assign pad_row = (NB*8)'(c1_row_reg);

    always_comb
    begin
        for (int b = 0; b < NB; b++)
        begin
            byte_cnt[b] = '0;
            for (int i = 0; i < 8; i++)
            begin
                byte_cnt[b] = byte_cnt[b] + 4'(pad_row[b*8+i]);
            end
        end
        for (int g = 0; g < NGRP; g++)
        begin
            grp_sum[g] = '0;
            for (int i = 0; i < 8; i++)
            begin
                grp_sum[g] = grp_sum[g] + 7'(c2_reg[g*8+i]);
            end
        end
        row_sum = '0;
        for (int g = 0; g < NGRP; g++)
        begin
            row_sum = row_sum + CNT_W'(c3_reg[g]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c1_vld_reg <= 1'b0;
            c2_vld_reg <= 1'b0;
            c3_vld_reg <= 1'b0;
            acc_reg    <= '0;
        end
        else
        begin
            c1_vld_reg <= m_en || p2_cen_reg;
            c2_vld_reg <= c1_vld_reg;
            c3_vld_reg <= c2_vld_reg;
            if (cmd.clear_acc)
            begin
                acc_reg <= '0;
            end
            else if (c3_vld_reg)
            begin
                acc_reg <= acc_reg + row_sum;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c1_row_reg <= (p2_cen_reg ? nxt_row : mod_row) & colmask;
        c2_reg     <= byte_cnt;
        c3_reg     <= grp_sum;
    end

    // result register
    logic             read_value_reg;
    logic [CNT_W-1:0] live_count_reg;
    logic             oor_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            read_value_reg <= rd_bit_reg;
            live_count_reg <= acc_reg;
            oor_reg        <= !inside_reg
                              && (action_reg == ACT_WRITE || action_reg == ACT_READ);
        end
    end

    assign read_value   = read_value_reg;
    assign live_count   = live_count_reg;
    assign out_of_range = oor_reg;

endmodule

FILE: rtl/life_automaton_generation_step.sv
// ----------------------------------------------------------------------------
// life_automaton_generation_step
// Toroidal B3/S23 life grid: cell write, cell read and one-generation
// advance, each answered with the read cell, live count and range flag.
// ----------------------------------------------------------------------------
// Usage
//   item   : valid/ready input, one transaction per action (write, read,
//            advance); ready is high only while the block is idle.
//   result : valid/ready output, exactly one transaction per item, held in
//            an output register until taken.
//   cfg    : valid/ready write port for row_count (index 0) and col_count
//            (index 1), always ready; write only while no item is pending.
// Timing
//   every item sweeps the rows in use through the row-wide datapath, one
//   grid row per cycle from a single-read, single-write row memory; the
//   next item is taken in the cycle after the result is loaded, so items
//   are never overlapped
// Reset
//   rst_n clears the grid through per-row valid bits, no clearing pass;
//   sizes return to 20 rows by 40 columns. A stalled result holds the block
//   in its final state until the receiver takes the pending one.
// ----------------------------------------------------------------------------
module life_automaton_generation_step #(
    parameter int MAX_ROWS = lags_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lags_pkg::MAX_COLS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lags_in_if.sink     item,
    lags_out_if.source  result,
    lags_cfg_if.sink    cfg
);
    import lags_pkg::*;

    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);

    lags_cmd_t         cmd;
    lags_sts_t         sts;
    logic [ROW_W-1:0]  rd_addr;
    logic [ROW_W-1:0]  cmp_row;
    logic [RCNT_W-1:0] rows;
    logic              cfg_we;

    assign cfg.ready = 1'b1;
    assign cfg_we    = cfg.valid;

    lags_ctrl #(
        .MAX_ROWS (MAX_ROWS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item.valid),
        .item_ready (item.ready),
        .out_valid  (result.valid),
        .out_ready  (result.ready),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .cmp_row    (cmp_row),
        .sts        (sts),
        .rows       (rows)
    );

    lags_dp #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .cmp_row      (cmp_row),
        .sts          (sts),
        .rows         (rows),
        .action       (item.action),
        .row_index    (item.row_index),
        .col_index    (item.col_index),
        .new_value    (item.new_value),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg.index),
        .cfg_data     (cfg.data),
        .read_value   (result.read_value),
        .live_count   (result.live_count),
        .out_of_range (result.out_of_range)
    );

endmodule
